>>> rtl/core/bucket_bitpack_dump_encoder_core_defines.svh
// ----------------------------------------------------------------------------
// Bucket bitpack dump encoder - assertion macros
// Shared concurrent assertion helpers, clocked on i_clk; BBDE_ASSERT is held off in reset.
// ----------------------------------------------------------------------------
`ifndef BUCKET_BITPACK_DUMP_ENCODER_CORE_DEFINES_SVH
`define BUCKET_BITPACK_DUMP_ENCODER_CORE_DEFINES_SVH

// implication checked on every clock edge out of reset
`define BBDE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// check that holds through reset as well
`define BBDE_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

>>> rtl/core/bbde_pkg.sv
// ----------------------------------------------------------------------------
// Bucket bitpack dump encoder - package
// Request codes, register indexes, stream bytes and the slot command type.
// ----------------------------------------------------------------------------
package bbde_pkg;

    localparam int NUM_SLOTS   = 9;
    localparam int SLOT_W      = $clog2(NUM_SLOTS);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] REQ_START  = 2'd0;
    localparam logic [1:0] REQ_SAMPLE = 2'd1;
    localparam logic [1:0] REQ_FINISH = 2'd2;

    localparam logic [2:0] REG_EXC_LOW    = 3'd0;
    localparam logic [2:0] REG_EXC_HIGH   = 3'd1;
    localparam logic [2:0] REG_EDGE_ONE   = 3'd2;
    localparam logic [2:0] REG_EDGE_TWO   = 3'd3;
    localparam logic [2:0] REG_EDGE_THREE = 3'd4;
    localparam logic [2:0] REG_EDGE_FOUR  = 3'd5;
    localparam logic [2:0] REG_INTERVAL   = 3'd6;

    localparam logic signed [15:0] RST_EXC_LOW    = 16'sd2200;
    localparam logic signed [15:0] RST_EXC_HIGH   = 16'sd2300;
    localparam logic signed [15:0] RST_EDGE_ONE   = 16'sd2200;
    localparam logic signed [15:0] RST_EDGE_TWO   = 16'sd2400;
    localparam logic signed [15:0] RST_EDGE_THREE = 16'sd2600;
    localparam logic signed [15:0] RST_EDGE_FOUR  = 16'sd2800;
    localparam logic [7:0]         RST_INTERVAL   = 8'd50;

    localparam logic [7:0] MARK_STAMP  = 8'hF0;
    localparam logic [7:0] MARK_EXC    = 8'hE5;
    localparam logic [7:0] MARK_END    = 8'hEE;
    localparam logic [7:0] HDR_MAGIC   = 8'hC1;
    localparam logic [7:0] HDR_VERSION = 8'h01;
    localparam logic [7:0] HDR_TAIL    = 8'h05;

    // byte slots of one command, sent lowest first
    localparam int SLOT_FLUSH     = 0;
    localparam int SLOT_STAMP     = 1;
    localparam int SLOT_STAMP_EXC = 6;
    localparam int SLOT_CHANGE    = 7;
    localparam int SLOT_PACK      = 8;

    typedef struct packed {
        logic [NUM_SLOTS-1:0]      mask;
        logic [NUM_SLOTS-1:0][7:0] bytes;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

>>> rtl/core/bbde_front.sv
// ----------------------------------------------------------------------------
// Bucket bitpack dump encoder - front end
// Holds configuration and stream state, classifies each request and builds
// the slot command for its output bytes.
// ----------------------------------------------------------------------------
module bbde_front
    import bbde_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic        i_push,
    input  logic [1:0]  i_req_type,
    input  logic [31:0] i_sample_time,
    input  logic signed [15:0] i_temp_centi,
    input  logic [15:0] i_record_count,
    input  t_q_stat     i_q_stat,
    output logic        o_q_push,
    output t_cmd        o_q_cmd
);

    logic signed [15:0] r_exc_low, r_exc_high;
    logic signed [15:0] r_edge_one, r_edge_two, r_edge_three, r_edge_four;
    logic [7:0]         r_interval;

    logic [7:0] r_phase, n_phase;
    logic [7:0] r_pack, n_pack;
    logic [2:0] r_fill, n_fill;
    logic       r_seen, n_seen;
    logic       r_exc, n_exc;

    logic       accept;
    logic       exc;
    logic [2:0] bucket;
    logic       flush;
    logic [7:0] pb_base, packed_byte;
    logic [2:0] f_base;
    logic [3:0] f_sum;
    t_cmd       cmd;

    assign accept = i_push && !i_q_stat.full;

    always_comb begin
        exc = (i_temp_centi < r_exc_low) || (i_temp_centi > r_exc_high);
        if (i_temp_centi < r_edge_one) begin
            bucket = 3'd0;
        end else if (i_temp_centi < r_edge_two) begin
            bucket = 3'd1;
        end else if (i_temp_centi < r_edge_three) begin
            bucket = 3'd2;
        end else if (i_temp_centi < r_edge_four) begin
            bucket = 3'd3;
        end else begin
            bucket = 3'd4;
        end
    end

    always_comb begin
        cmd         = '0;
        n_phase     = r_phase;
        n_pack      = r_pack;
        n_fill      = r_fill;
        n_seen      = r_seen;
        n_exc       = r_exc;
        flush       = 1'b0;
        pb_base     = r_pack;
        f_base      = r_fill;
        packed_byte = '0;
        f_sum       = '0;
        case (i_req_type)
            REQ_START: begin
                cmd.mask[5:1]  = '1;
                cmd.bytes[1]   = HDR_MAGIC;
                cmd.bytes[2]   = HDR_VERSION;
                cmd.bytes[3]   = i_record_count[7:0];
                cmd.bytes[4]   = i_record_count[15:8];
                cmd.bytes[5]   = HDR_TAIL;
                n_phase = '0;
                n_pack  = '0;
                n_fill  = '0;
                n_seen  = 1'b0;
                n_exc   = 1'b0;
            end
            REQ_SAMPLE: begin
                flush = (r_fill != 3'd0) &&
                        ((r_phase == 8'd0) || (r_seen && (exc != r_exc)));
                cmd.mask[SLOT_FLUSH]  = flush;
                cmd.bytes[SLOT_FLUSH] = r_pack;
                if (r_phase == 8'd0) begin
                    cmd.mask[SLOT_STAMP+4:SLOT_STAMP] = '1;
                    cmd.bytes[SLOT_STAMP]     = MARK_STAMP;
                    cmd.bytes[SLOT_STAMP+1]   = i_sample_time[7:0];
                    cmd.bytes[SLOT_STAMP+2]   = i_sample_time[15:8];
                    cmd.bytes[SLOT_STAMP+3]   = i_sample_time[23:16];
                    cmd.bytes[SLOT_STAMP+4]   = i_sample_time[31:24];
                    cmd.mask[SLOT_STAMP_EXC]  = r_seen && r_exc;
                    cmd.bytes[SLOT_STAMP_EXC] = MARK_EXC;
                end
                cmd.mask[SLOT_CHANGE]  = r_seen && (exc != r_exc);
                cmd.bytes[SLOT_CHANGE] = MARK_EXC;
                pb_base     = flush ? 8'd0 : r_pack;
                f_base      = flush ? 3'd0 : r_fill;
                packed_byte = pb_base | (8'({5'd0, bucket}) << f_base);
                f_sum       = {1'b0, f_base} + 4'd3;
                if (f_sum[3]) begin
                    cmd.mask[SLOT_PACK]  = 1'b1;
                    cmd.bytes[SLOT_PACK] = packed_byte;
                    n_fill = f_sum[2:0];
                    n_pack = (f_sum[2:0] != 3'd0) ?
                             8'({5'd0, bucket} >> (3'd3 - f_sum[2:0])) : 8'd0;
                end else begin
                    n_fill = f_sum[2:0];
                    n_pack = packed_byte;
                end
                n_seen = 1'b1;
                n_exc  = exc;
                if (({1'b0, r_phase} + 9'd1) >= {1'b0, r_interval}) begin
                    n_phase = '0;
                end else begin
                    n_phase = r_phase + 8'd1;
                end
            end
            REQ_FINISH: begin
                cmd.mask[SLOT_FLUSH]  = r_fill != 3'd0;
                cmd.bytes[SLOT_FLUSH] = r_pack;
                cmd.mask[1]  = 1'b1;
                cmd.bytes[1] = MARK_END;
                n_pack = '0;
                n_fill = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exc_low    <= RST_EXC_LOW;
            r_exc_high   <= RST_EXC_HIGH;
            r_edge_one   <= RST_EDGE_ONE;
            r_edge_two   <= RST_EDGE_TWO;
            r_edge_three <= RST_EDGE_THREE;
            r_edge_four  <= RST_EDGE_FOUR;
            r_interval   <= RST_INTERVAL;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_EXC_LOW:    r_exc_low    <= i_cfg_data;
                REG_EXC_HIGH:   r_exc_high   <= i_cfg_data;
                REG_EDGE_ONE:   r_edge_one   <= i_cfg_data;
                REG_EDGE_TWO:   r_edge_two   <= i_cfg_data;
                REG_EDGE_THREE: r_edge_three <= i_cfg_data;
                REG_EDGE_FOUR:  r_edge_four  <= i_cfg_data;
                REG_INTERVAL:   r_interval   <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_pack  <= '0;
            r_fill  <= '0;
            r_seen  <= 1'b0;
            r_exc   <= 1'b0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_pack  <= n_pack;
            r_fill  <= n_fill;
            r_seen  <= n_seen;
            r_exc   <= n_exc;
        end
    end

    assign o_q_push = accept && (cmd.mask != '0);
    assign o_q_cmd  = cmd;

endmodule

>>> rtl/core/bbde_queue.sv
// ----------------------------------------------------------------------------
// Bucket bitpack dump encoder - command queue
// Short register queue of slot commands between front and back end.
// ----------------------------------------------------------------------------
module bbde_queue
    import bbde_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_cmd    i_cmd,
    input  logic    i_pop,
    output t_cmd    o_cmd,
    output t_q_stat o_stat
);

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    assign o_cmd        = r_mem[r_rd_ptr];
    assign o_stat.full  = r_count == QCNT_W'(QUEUE_DEPTH);
    assign o_stat.empty = r_count == '0;

endmodule

>>> rtl/core/bbde_back.sv
// ----------------------------------------------------------------------------
// Bucket bitpack dump encoder - back end
// Walks the set slots of each command, one byte a cycle while the output is
// not stalled, into the output register.
// ----------------------------------------------------------------------------
`include "bucket_bitpack_dump_encoder_core_defines.svh"

module bbde_back
    import bbde_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_q_cmd,
    input  t_q_stat    i_q_stat,
    output logic       o_q_pop,
    input  logic       i_pop,
    output logic       o_empty,
    output logic [7:0] o_out_byte,
    output logic       o_last_of_run
);

    logic [NUM_SLOTS-1:0]      r_mask, n_mask;
    logic [NUM_SLOTS-1:0][7:0] r_bytes;
    logic                      r_out_valid;
    logic [7:0]                r_out_byte;
    logic                      r_out_last;

    logic [SLOT_W-1:0]    sel;
    logic [NUM_SLOTS-1:0] remaining;
    logic                 adv;
    logic                 load;

    always_comb begin
        sel = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (r_mask[i]) begin
                sel = SLOT_W'(i);
            end
        end
    end

    always_comb begin
        remaining = r_mask;
        remaining[sel] = 1'b0;
    end

    assign adv    = (r_mask != '0) && (!r_out_valid || i_pop);
    assign n_mask = adv ? remaining : r_mask;
    assign load   = (n_mask == '0) && !i_q_stat.empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_mask <= load ? i_q_cmd.mask : n_mask;
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_bytes <= i_q_cmd.bytes;
        end
        if (adv) begin
            r_out_byte <= r_bytes[sel];
            r_out_last <= remaining == '0;
        end
    end

    assign o_q_pop       = load;
    assign o_empty       = !r_out_valid;
    assign o_out_byte    = r_out_byte;
    assign o_last_of_run = r_out_last;

    `BBDE_ASSERT(a_pop_nonempty, o_q_pop |-> !i_q_stat.empty, "queue popped while empty")
    `BBDE_ASSERT(a_load_nonzero, o_q_pop |=> (r_mask != '0), "empty command loaded")
    `BBDE_ASSERT(a_adv_shows, adv |=> r_out_valid, "byte sent but output not valid")
    `BBDE_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> (o_empty && (r_mask == '0)),
        "not idle after reset")

endmodule

>>> rtl/core/bucket_bitpack_dump_encoder_core.sv
// ----------------------------------------------------------------------------
// Bucket bitpack dump encoder - top level
// Turns start, sample and finish requests into a compact byte stream.
// ----------------------------------------------------------------------------
// Input side is a queue write: a request is taken on a rising edge with push
// high and full low. Output side is a queue read: the oldest byte is on
// o_out_byte / o_last_of_run while empty is low and leaves on an edge with pop
// high. o_last_of_run marks the final byte a request produces; requests that
// produce nothing (unknown type, a sample that only adds bits) show nothing.
// The front end takes one request a cycle while full is low and turns it into
// a slot command in the same cycle; a two-deep command queue sits in front of
// the back end. The back end sends one byte a cycle while pop keeps up, and a
// request makes 0 to 8 bytes (header 5). The first byte of a request passes
// through the command queue and the back end's slot register to the output.
// When the reader stalls the output register holds, the back end stops and
// full rises once the queue holds two commands.
// Configuration is written through i_cfg_we / i_cfg_idx / i_cfg_data while
// idle. Reset restores register defaults and clears all stream state.
// ----------------------------------------------------------------------------
module bucket_bitpack_dump_encoder_core
    import bbde_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_req_type,
    input  logic [31:0] i_sample_time,
    input  logic signed [15:0] i_temp_centi,
    input  logic [15:0] i_record_count,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_out_byte,
    output logic        o_last_of_run
);

    logic    q_push, q_pop;
    t_cmd    q_in_cmd, q_out_cmd;
    t_q_stat q_stat;

    bbde_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_push         (push),
        .i_req_type     (i_req_type),
        .i_sample_time  (i_sample_time),
        .i_temp_centi   (i_temp_centi),
        .i_record_count (i_record_count),
        .i_q_stat       (q_stat),
        .o_q_push       (q_push),
        .o_q_cmd        (q_in_cmd)
    );

    bbde_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in_cmd),
        .i_pop   (q_pop),
        .o_cmd   (q_out_cmd),
        .o_stat  (q_stat)
    );

    bbde_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_cmd       (q_out_cmd),
        .i_q_stat      (q_stat),
        .o_q_pop       (q_pop),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_out_byte    (o_out_byte),
        .o_last_of_run (o_last_of_run)
    );

    assign full = q_stat.full;

endmodule
